### hw/rtl/gha_pkg.sv
// Package for the generational handle allocator: sizes, codes, controller
// states and the command and status bundles between controller and datapath.
// No dependencies.
package gha_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GEN_W    = 32;
  localparam int SLOT_W   = GEN_W + 1;

  localparam int FUNC_W     = 2;
  localparam int IN_IDX_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_IDX_W  = 10;
  localparam int LIVE_W     = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-3:0] REG_INIT_GEN = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_CHECK   = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_STALE   = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_POP     = 2'd1,
    S_SLOT_RD = 2'd2,
    S_EXEC    = 2'd3
  } state_e;

  typedef struct packed {
    logic capture;
    logic stack_rd;
    logic slot_rd;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic stack_empty;
  } sts_t;

endpackage

### hw/rtl/gha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gha_regs.sv
// APB configuration register block holding the initial generation.
// Depends on gha_pkg.
module gha_regs
  import gha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [GEN_W-1:0]      init_gen_o
);

  logic [GEN_W-1:0] init_gen_q, init_gen_d;
  logic             hit;

  assign hit = (paddr[APB_ADDR_W-1:2] == REG_INIT_GEN);

  always_comb begin
    init_gen_d = init_gen_q;
    if (psel && penable && pwrite && hit) begin
      init_gen_d = pwdata[GEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_gen_q <= GEN_W'(1);
    end else begin
      init_gen_q <= init_gen_d;
    end
  end

  assign prdata     = hit ? APB_DATA_W'(init_gen_q) : '0;
  assign pready     = 1'b1;
  assign init_gen_o = init_gen_q;

endmodule

### hw/rtl/gha_ctrl.sv
// Controller state machine that sequences stack reads, slot reads and the
// final update of each operation. Depends on gha_pkg.
module gha_ctrl
  import gha_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FUNC_W-1:0] func_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o,
  output logic              busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_CREATE && !sts_i.stack_empty) begin
            state_d = S_POP;
          end else if (func_i == FUNC_CREATE || func_i == FUNC_CLEAR) begin
            state_d = S_EXEC;
          end else begin
            state_d = S_SLOT_RD;
          end
        end
      end
      S_POP:     state_d = S_SLOT_RD;
      S_SLOT_RD: state_d = S_EXEC;
      S_EXEC:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      S_POP:     cmd_o.stack_rd = 1'b1;
      S_SLOT_RD: cmd_o.slot_rd  = 1'b1;
      S_EXEC:    cmd_o.execute  = 1'b1;
      default:   busy_o         = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/gha_dp.sv
// Datapath: slot and free-stack memories, high-water mark, stack depth and
// the result register. Depends on gha_pkg and gha_ram.
module gha_dp
  import gha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [IN_IDX_W-1:0] slot_index_i,
  input  logic [GEN_W-1:0]    handle_generation_i,
  input  logic [GEN_W-1:0]    init_gen_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [OUT_IDX_W-1:0] out_index_o,
  output logic [GEN_W-1:0]    out_generation_o,
  output logic                present_o,
  output logic [LIVE_W-1:0]   live_count_o
);

  func_e               op_q;
  logic [IN_IDX_W-1:0] idx_q;
  logic [GEN_W-1:0]    hgen_q;
  logic [IDX_W-1:0]    pop_idx_q;
  logic [CNT_W-1:0]    hwm_q, hwm_d;
  logic [CNT_W-1:0]    depth_q, depth_d;

  logic                done_q;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    oidx_q, oidx_d;
  logic [GEN_W-1:0]    ogen_q, ogen_d;
  logic                present_q, present_d;
  logic [CNT_W-1:0]    live_q;

  logic [IDX_W-1:0]    stk_rdata;
  logic [SLOT_W-1:0]   slot_rdata;
  logic [IDX_W-1:0]    slot_raddr;
  logic                slot_we, stk_we;
  logic [IDX_W-1:0]    slot_waddr;
  logic [SLOT_W-1:0]   slot_wdata;

  logic                occ, match, idx_ok;
  logic [GEN_W-1:0]    sgen, gen_inc;

  assign sts_o.stack_empty = (depth_q == '0);

  assign slot_raddr = (op_q == FUNC_CREATE) ? stk_rdata : idx_q[IDX_W-1:0];
  assign occ        = slot_rdata[GEN_W];
  assign sgen       = slot_rdata[GEN_W-1:0];
  assign idx_ok     = (32'(idx_q) < 32'(hwm_q));
  assign match      = occ && (sgen == hgen_q);
  assign gen_inc    = ((sgen + GEN_W'(1)) == '0) ? GEN_W'(1) : (sgen + GEN_W'(1));

  always_comb begin
    hwm_d      = hwm_q;
    depth_d    = depth_q;
    status_d   = ST_OK;
    oidx_d     = '0;
    ogen_d     = '0;
    present_d  = 1'b0;
    slot_we    = 1'b0;
    stk_we     = 1'b0;
    slot_waddr = idx_q[IDX_W-1:0];
    slot_wdata = {1'b0, gen_inc};
    case (op_q)
      FUNC_CREATE: begin
        if (depth_q != '0) begin
          depth_d    = depth_q - CNT_W'(1);
          slot_we    = 1'b1;
          slot_waddr = pop_idx_q;
          slot_wdata = {1'b1, sgen};
          oidx_d     = pop_idx_q;
          ogen_d     = sgen;
        end else if (hwm_q < CNT_W'(CAPACITY)) begin
          hwm_d      = hwm_q + CNT_W'(1);
          slot_we    = 1'b1;
          slot_waddr = hwm_q[IDX_W-1:0];
          slot_wdata = {1'b1, init_gen_i};
          oidx_d     = hwm_q[IDX_W-1:0];
          ogen_d     = init_gen_i;
        end else begin
          status_d = ST_LIMIT;
        end
      end
      FUNC_DESTROY: begin
        if (hgen_q == '0 || !idx_ok) begin
          status_d = ST_INVALID;
        end else if (!match) begin
          status_d = ST_STALE;
        end else begin
          slot_we = 1'b1;
          if (depth_q < CNT_W'(CAPACITY)) begin
            stk_we  = 1'b1;
            depth_d = depth_q + CNT_W'(1);
          end
        end
      end
      FUNC_CHECK: begin
        present_d = (hgen_q != '0) && idx_ok && match;
      end
      FUNC_CLEAR: begin
        hwm_d   = '0;
        depth_d = '0;
      end
      default: status_d = ST_OK;
    endcase
  end

  gha_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.execute && slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (cmd_i.slot_rd),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  gha_ram #(
    .WIDTH(IDX_W),
    .DEPTH(CAPACITY)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.execute && stk_we),
    .waddr_i(depth_q[IDX_W-1:0]),
    .wdata_i(idx_q[IDX_W-1:0]),
    .re_i   (cmd_i.stack_rd),
    .raddr_i(depth_q[IDX_W-1:0] - IDX_W'(1)),
    .rdata_o(stk_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= func_e'(func_i);
      idx_q  <= slot_index_i;
      hgen_q <= handle_generation_i;
    end
    if (cmd_i.slot_rd) begin
      pop_idx_q <= stk_rdata;
    end
    if (cmd_i.execute) begin
      status_q  <= status_d;
      oidx_q    <= oidx_d;
      ogen_q    <= ogen_d;
      present_q <= present_d;
      live_q    <= hwm_d - depth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwm_q   <= '0;
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        hwm_q   <= hwm_d;
        depth_q <= depth_d;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_index_o      = OUT_IDX_W'(oidx_q);
  assign out_generation_o = ogen_q;
  assign present_o        = present_q;
  assign live_count_o     = LIVE_W'(live_q);

endmodule

### hw/rtl/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator: controller, datapath and
// configuration registers. Depends on gha_pkg, gha_regs, gha_ctrl and gha_dp.
//
// Channel   Direction  Handshake                  Payload
// command   in         start, busy                func_i, slot_index_i,
//                                                 handle_generation_i
// result    out        done_o (one-cycle strobe)  status_o, out_index_o,
//                                                 out_generation_o, present_o,
//                                                 live_count_o
// config    in         psel, penable, pwrite      paddr, pwdata, prdata
//
// A transaction is accepted when start is high and busy is low; busy then
// stays high while the operation runs through the slot and stack memories.
// Create from the high-water mark and clear go straight from idle to the execute
// state, destroy and check pass through the slot read first, and create from the free
// stack passes through the stack read followed by the dependent slot read.
// The result strobe comes in the cycle after the last busy cycle and cannot be
// stalled. Reset clears the control state at once; memories need no sweep.
module generational_handle_allocator_unit
  import gha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [IN_IDX_W-1:0]   slot_index_i,
  input  logic [GEN_W-1:0]      handle_generation_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [OUT_IDX_W-1:0]  out_index_o,
  output logic [GEN_W-1:0]      out_generation_o,
  output logic                  present_o,
  output logic [LIVE_W-1:0]     live_count_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cmd_t             cmd;
  sts_t             sts;
  logic [GEN_W-1:0] init_gen;

  gha_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .init_gen_o(init_gen)
  );

  gha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  gha_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .func_i             (func_i),
    .slot_index_i       (slot_index_i),
    .handle_generation_i(handle_generation_i),
    .init_gen_i         (init_gen),
    .done_o             (done_o),
    .status_o           (status_o),
    .out_index_o        (out_index_o),
    .out_generation_o   (out_generation_o),
    .present_o          (present_o),
    .live_count_o       (live_count_o)
  );

endmodule

### hw/rtl/gha_chk.sv
// Port-level assertions for the generational handle allocator, bound to the
// top level. Depends on gha_pkg and generational_handle_allocator_unit.
module gha_chk
  import gha_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [STATUS_W-1:0]  status_o,
  input logic [OUT_IDX_W-1:0] out_index_o,
  input logic [GEN_W-1:0]     out_generation_o,
  input logic                 present_o,
  input logic [LIVE_W-1:0]    live_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobes in consecutive cycles");

  a_limit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_LIMIT |-> out_index_o == '0 && out_generation_o == '0)
    else $error("limit result carries a handle");

  a_present_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && present_o |-> status_o == ST_OK && out_generation_o == '0)
    else $error("present result with bad status or generation");

  a_live_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(live_count_o) <= 32'(CAPACITY))
    else $error("live count above capacity");

endmodule

bind generational_handle_allocator_unit gha_chk u_gha_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .out_index_o     (out_index_o),
  .out_generation_o(out_generation_o),
  .present_o       (present_o),
  .live_count_o    (live_count_o)
);

### tb/tb_top.sv
// Self-checking testbench for generational_handle_allocator_unit: a directed command table,
// random create/destroy/check/clear traffic and APB register writes, checked against an
// in-bench slot table model or typed row values. Depends on gha_pkg and the allocator RTL.
module tb_top;
  import gha_pkg::*;

  localparam int WATCHDOG_CYCLES = 300000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_PRINTS      = 40;
  localparam int PHASE_ITEMS     = 250;

  typedef struct packed {
    status_e              st;
    logic [OUT_IDX_W-1:0] idx;
    logic [GEN_W-1:0]     gen;
    logic                 present;
    logic [LIVE_W-1:0]    live;
  } alloc_res_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;
  typedef enum int {MIX_NORMAL, MIX_FILL, MIX_FULL} mix_e;

  typedef struct {
    row_kind_e             kind;
    func_e                 func;
    logic [IN_IDX_W-1:0]   idx;
    logic [GEN_W-1:0]      gen;
    bit                    typed;
    alloc_res_t            want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i;
  logic [IN_IDX_W-1:0]   slot_index_i;
  logic [GEN_W-1:0]      handle_generation_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [OUT_IDX_W-1:0]  out_index_o;
  logic [GEN_W-1:0]      out_generation_o;
  logic                  present_o;
  logic [LIVE_W-1:0]     live_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Model of the slot table, advanced once per accepted transaction.
  logic [GEN_W-1:0]     slot_gen  [CAPACITY];
  bit                   slot_busy [CAPACITY];
  logic [OUT_IDX_W-1:0] free_stk  [CAPACITY];
  int                   stk_depth = 0;
  int                   hwm = 0;
  logic [GEN_W-1:0]     init_gen = 32'd1;

  alloc_res_t pending_q[$];
  dir_row_t   rows[$];
  int n_err = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_cfg = 0;
  int cycles = 0;

  generational_handle_allocator_unit dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (n_err < MAX_PRINTS) begin
      $display("MISMATCH %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
    end
    n_err++;
  endtask

  function automatic void add_row(input dir_row_t row);
    rows.insert(rows.size(), row);
  endfunction

  function automatic alloc_res_t alloc_model(input func_e f, input logic [IN_IDX_W-1:0] idx,
                                             input logic [GEN_W-1:0] g);
    alloc_res_t           r;
    logic [OUT_IDX_W-1:0] s;
    logic [GEN_W-1:0]     ng;
    bit                   hit;
    r = '0;
    s = idx[OUT_IDX_W-1:0];
    hit = g != '0 && idx < hwm && slot_busy[s] && slot_gen[s] == g;
    case (f)
      FUNC_CREATE: begin
        if (stk_depth > 0) begin
          stk_depth--;
          s = free_stk[stk_depth];
          slot_busy[s] = 1'b1;
          r.idx = s;
          r.gen = slot_gen[s];
        end else if (hwm < CAPACITY) begin
          s = OUT_IDX_W'(hwm);
          hwm++;
          slot_gen[s] = init_gen;
          slot_busy[s] = 1'b1;
          r.idx = s;
          r.gen = init_gen;
        end else begin
          r.st = ST_LIMIT;
          n_full++;
        end
      end
      FUNC_DESTROY: begin
        if (g == '0 || idx >= hwm) begin
          r.st = ST_INVALID;
        end else if (!hit) begin
          r.st = ST_STALE;
        end else begin
          ng = slot_gen[s] + 1'b1;
          if (ng == '0) ng = 32'd1;
          slot_gen[s] = ng;
          slot_busy[s] = 1'b0;
          if (stk_depth < CAPACITY) begin
            free_stk[stk_depth] = s;
            stk_depth++;
          end
        end
      end
      FUNC_CHECK: r.present = hit;
      default: begin
        hwm = 0;
        stk_depth = 0;
      end
    endcase
    r.live = LIVE_W'(hwm - stk_depth);
    return r;
  endfunction

  // Destroy and check mostly name live handles; the rest are stale, zero, out of range or random.
  function automatic void pick_cmd(input mix_e mix, output func_e f,
                                   output logic [IN_IDX_W-1:0] idx, output logic [GEN_W-1:0] g);
    int r;
    int h;
    int c;
    r = $urandom_range(99);
    idx = IN_IDX_W'($urandom);
    g = $urandom;
    if (mix == MIX_FILL) begin
      if (r < 85) f = FUNC_CREATE;
      else if (r < 93) f = FUNC_DESTROY;
      else f = FUNC_CHECK;
    end else if (mix == MIX_FULL) begin
      if (r < 40) f = FUNC_CREATE;
      else if (r < 75) f = FUNC_DESTROY;
      else f = FUNC_CHECK;
    end else begin
      if (r < 35) f = FUNC_CREATE;
      else if (r < 65) f = FUNC_DESTROY;
      else if (r < 97) f = FUNC_CHECK;
      else f = FUNC_CLEAR;
    end
    if ((f == FUNC_DESTROY || f == FUNC_CHECK) && hwm > 0) begin
      h = $urandom_range(99);
      c = $urandom_range(hwm - 1);
      if (h < 70) begin
        for (int k = 0; k < 8 && !slot_busy[c]; k++) c = $urandom_range(hwm - 1);
        idx = IN_IDX_W'(c);
        g = slot_gen[c];
      end else if (h < 85) begin
        idx = IN_IDX_W'(c);
        g = slot_gen[c] ^ (32'd1 << $urandom_range(31));
      end else if (h < 91) begin
        idx = IN_IDX_W'(c);
        g = '0;
      end else if (h < 95) begin
        idx = IN_IDX_W'(hwm);
      end
    end
  endfunction

  function automatic dir_row_t op_row(input func_e f, input logic [IN_IDX_W-1:0] idx,
                                      input logic [GEN_W-1:0] g);
    dir_row_t row;
    row.kind = ROW_CMD;
    row.func = f;
    row.idx = idx;
    row.gen = g;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t op_want(input func_e f, input logic [IN_IDX_W-1:0] idx,
                                       input logic [GEN_W-1:0] g, input status_e st,
                                       input logic [OUT_IDX_W-1:0] oidx,
                                       input logic [GEN_W-1:0] ogen, input bit pres,
                                       input logic [LIVE_W-1:0] live);
    dir_row_t row;
    row = op_row(f, idx, g);
    row.typed = 1'b1;
    row.want.st = st;
    row.want.idx = oidx;
    row.want.gen = ogen;
    row.want.present = pres;
    row.want.live = live;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [GEN_W-1:0] val);
    dir_row_t row;
    row = op_row(FUNC_CREATE, '0, val);
    row.kind = ROW_CFG;
    return row;
  endfunction

  task automatic send_cmd(input func_e f, input logic [IN_IDX_W-1:0] idx,
                          input logic [GEN_W-1:0] g, input int idle_pct,
                          input bit typed, input alloc_res_t want);
    alloc_res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    slot_index_i <= idx;
    handle_generation_i <= g;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pred = alloc_model(f, idx, g);
    pending_q.insert(pending_q.size(), typed ? want : pred);
    n_items++;
  endtask

  task automatic write_init_gen(input logic [GEN_W-1:0] val);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_INIT_GEN, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    init_gen = val;
    n_cfg++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== val) begin
      flag_mismatch("initial_generation readback", 64'(prdata), 64'(val));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_mon
    alloc_res_t e;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_q.size() == 0) begin
        flag_mismatch("result with no transaction outstanding", 64'(status_o), 64'(0));
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (status_o !== e.st) flag_mismatch("status", 64'(status_o), 64'(e.st));
        if (out_index_o !== e.idx) begin
          flag_mismatch("out_index", 64'(out_index_o), 64'(e.idx));
        end
        if (out_generation_o !== e.gen) begin
          flag_mismatch("out_generation", 64'(out_generation_o), 64'(e.gen));
        end
        if (present_o !== e.present) begin
          flag_mismatch("present", 64'(present_o), 64'(e.present));
        end
        if (live_count_o !== e.live) begin
          flag_mismatch("live_count", 64'(live_count_o), 64'(e.live));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Watchdog expired after %0d cycles with %0d results outstanding.",
             cycles, pending_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    func_e               f;
    logic [IN_IDX_W-1:0] idx;
    logic [GEN_W-1:0]    g;
    int                  idle_tbl[3];
    logic [GEN_W-1:0]    gen_tbl[3];
    rst_ni <= 1'b0;
    start <= 1'b0;
    func_i <= FUNC_CREATE;
    slot_index_i <= '0;
    handle_generation_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Starting from reset with an initial generation of one.
    add_row(op_want(FUNC_CHECK, 16'd0, 32'd1, ST_OK, 0, 0, 1'b0, 0));
    add_row(op_want(FUNC_DESTROY, 16'd0, 32'd1, ST_INVALID, 0, 0, 1'b0, 0));
    add_row(op_want(FUNC_CREATE, 16'hFFFF, 32'hFFFF_FFFF, ST_OK, 0, 32'd1, 1'b0, 1));
    add_row(op_want(FUNC_CREATE, 16'd0, 32'd0, ST_OK, 1, 32'd1, 1'b0, 2));
    add_row(op_want(FUNC_CHECK, 16'd1, 32'd1, ST_OK, 0, 0, 1'b1, 2));
    add_row(op_want(FUNC_CHECK, 16'd0, 32'd0, ST_OK, 0, 0, 1'b0, 2));
    add_row(op_want(FUNC_DESTROY, 16'd0, 32'd0, ST_INVALID, 0, 0, 1'b0, 2));
    add_row(op_want(FUNC_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, ST_INVALID, 0, 0, 1'b0, 2));
    add_row(op_want(FUNC_DESTROY, 16'd1, 32'd2, ST_STALE, 0, 0, 1'b0, 2));
    add_row(op_want(FUNC_DESTROY, 16'd1, 32'd1, ST_OK, 0, 0, 1'b0, 1));
    add_row(op_want(FUNC_DESTROY, 16'd1, 32'd2, ST_STALE, 0, 0, 1'b0, 1));
    add_row(op_row(FUNC_CHECK, 16'd1, 32'd2));
    add_row(op_row(FUNC_CREATE, 16'h5A5A, 32'hA5A5_A5A5));
    add_row(op_row(FUNC_CHECK, 16'd1, 32'd1));
    add_row(op_want(FUNC_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, ST_OK, 0, 0, 1'b0, 0));
    add_row(op_want(FUNC_CHECK, 16'd0, 32'd1, ST_OK, 0, 0, 1'b0, 0));
    // Generation wrap past all ones, then an initial generation of zero.
    add_row(cfg_row(32'hFFFF_FFFF));
    add_row(op_want(FUNC_CREATE, 16'd0, 32'd0, ST_OK, 0, 32'hFFFF_FFFF, 1'b0, 1));
    add_row(op_want(FUNC_DESTROY, 16'd0, 32'hFFFF_FFFF, ST_OK, 0, 0, 1'b0, 0));
    add_row(op_row(FUNC_CREATE, 16'd0, 32'd0));
    add_row(cfg_row(32'd0));
    add_row(op_want(FUNC_CREATE, 16'd0, 32'd0, ST_OK, 1, 32'd0, 1'b0, 2));
    add_row(op_want(FUNC_DESTROY, 16'd1, 32'd0, ST_INVALID, 0, 0, 1'b0, 2));
    add_row(op_want(FUNC_CHECK, 16'd1, 32'd0, ST_OK, 0, 0, 1'b0, 2));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_init_gen(rows[i].gen);
      end else begin
        send_cmd(rows[i].func, rows[i].idx, rows[i].gen, 0, rows[i].typed, rows[i].want);
      end
    end

    idle_tbl[0] = 0;
    idle_tbl[1] = 69;
    idle_tbl[2] = 38;
    gen_tbl[0] = 32'd1;
    gen_tbl[1] = 32'hFFFF_FFFE;
    gen_tbl[2] = $urandom | 32'd1;
    for (int p = 0; p < 3; p++) begin
      write_init_gen(gen_tbl[p]);
      repeat (PHASE_ITEMS) begin
        pick_cmd(MIX_NORMAL, f, idx, g);
        send_cmd(f, idx, g, idle_tbl[p], 1'b0, '0);
      end
    end

    // Fill the table to capacity, then keep working against a full table.
    write_init_gen(32'hFFFF_FFFF);
    send_cmd(FUNC_CLEAR, '0, '0, 0, 1'b0, '0);
    while (n_full < 3) begin
      pick_cmd(MIX_FILL, f, idx, g);
      send_cmd(f, idx, g, (n_items % 200 < 100) ? 0 : 38, 1'b0, '0);
    end
    repeat (60) begin
      pick_cmd(MIX_FULL, f, idx, g);
      send_cmd(f, idx, g, 69, 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d allocator transactions over %0d initial generation settings,",
             n_items, n_cfg);
    $display("compared %0d results, with %0d creates against a full table.",
             n_checked, n_full);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
